// File: rtl/core/cbi_pkg.sv
// ----------------------------------------------------------------------------
// cbi_pkg
// shared widths, codes and defaults of the chroma block interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbi_pkg;

   // field widths
   localparam int ADDR_IN_W   = 12;
   localparam int SAMPLE_W    = 8;
   localparam int ORIGIN_W    = 11;
   localparam int SIZE_W      = 4;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   // command codes
   localparam logic CMD_WRITE = 1'b0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] PLANE_SIZE_RESET = 7'd64;

   // eighth-sample arithmetic
   localparam int EIGHTH_BITS = 3;
   localparam logic [EIGHTH_BITS:0] FRAC_ONE = 4'd8;
   localparam int BLEND_SHIFT = 2 * EIGHTH_BITS;
   localparam int ROUND_BIAS  = 32;

   // default sizes
   localparam int DEF_MAX_PLANE_WIDTH  = 64;
   localparam int DEF_MAX_PLANE_HEIGHT = 64;
   localparam int DEF_MAX_BLOCK_SIZE   = 8;

endpackage

// File: rtl/core/chroma_block_interpolator.sv
// ----------------------------------------------------------------------------
// chroma_block_interpolator
// predict: busy through a setup state and four reads per pixel (the four
//   reads go through the single read port of the sample memory)
// write: a write state, preceded by one reduction step per halving of the input
//   address span over the memory depth (none at the default depth)
// reset: synchronous, clears control and sets both plane sizes to 64; the
//   sample memory is not cleared; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_block_interpolator #(
   parameter int MAX_PLANE_WIDTH  = cbi_pkg::DEF_MAX_PLANE_WIDTH,
   parameter int MAX_PLANE_HEIGHT = cbi_pkg::DEF_MAX_PLANE_HEIGHT,
   parameter int MAX_BLOCK_SIZE   = cbi_pkg::DEF_MAX_BLOCK_SIZE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic [cbi_pkg::ADDR_IN_W-1:0]          req_write_address,
   input  logic [cbi_pkg::SAMPLE_W-1:0]           req_write_sample,
   input  logic signed [cbi_pkg::ORIGIN_W-1:0]    req_origin_x,
   input  logic signed [cbi_pkg::ORIGIN_W-1:0]    req_origin_y,
   input  logic [cbi_pkg::SIZE_W-1:0]             req_block_cols,
   input  logic [cbi_pkg::SIZE_W-1:0]             req_block_rows,
   // result channel
   output logic                                   rsp_strobe,
   output logic [cbi_pkg::SAMPLE_W-1:0]           rsp_pixel,
   output logic                                   rsp_last,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cbi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [cbi_pkg::CSR_DATA_W-1:0]         csr_data
);

   import cbi_pkg::*;

   // derived sizes
   localparam int SAMPLE_DEPTH = MAX_PLANE_WIDTH * MAX_PLANE_HEIGHT;
   localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
   localparam int PW_W    = $clog2(MAX_PLANE_WIDTH + 1);
   localparam int PH_W    = $clog2(MAX_PLANE_HEIGHT + 1);
   localparam int CX_W    = $clog2(MAX_PLANE_WIDTH);
   localparam int CY_W    = $clog2(MAX_PLANE_HEIGHT);
   localparam int XP_W    = CX_W + EIGHTH_BITS;
   localparam int YP_W    = CY_W + EIGHTH_BITS;
   localparam int POS_W   = ORIGIN_W + 1;
   localparam int CMPX_W  = (XP_W > POS_W - 1) ? XP_W : POS_W - 1;
   localparam int CMPY_W  = (YP_W > POS_W - 1) ? YP_W : POS_W - 1;
   localparam int BS_W    = $clog2(MAX_BLOCK_SIZE + 1);
   localparam int BI_W    = $clog2(MAX_BLOCK_SIZE);
   localparam int WT_W    = 2 * EIGHTH_BITS + 1;
   localparam int ACC_W   = SAMPLE_W + 2 * EIGHTH_BITS;
   // write address reduction modulo the memory depth, one shifted subtract a step
   localparam int IN_SPAN   = 2 ** ADDR_IN_W;
   localparam int MOD_STEPS = $clog2((IN_SPAN + SAMPLE_DEPTH - 1) / SAMPLE_DEPTH);
   localparam int K_W       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_SETUP  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;

   // read phases: the four bilinear neighbors
   localparam logic [1:0] PH_A = 2'd0;   // (cx,   cy)
   localparam logic [1:0] PH_B = 2'd1;   // (cx+1, cy)
   localparam logic [1:0] PH_C = 2'd2;   // (cx,   cy+1)
   localparam logic [1:0] PH_D = 2'd3;   // (cx+1, cy+1)

   // control and configuration
   logic [2:0]             state_ff, state_in;
   logic [CSR_DATA_W-1:0]  pw_ff, pw_in;
   logic [CSR_DATA_W-1:0]  ph_ff, ph_in;

   // write transaction
   logic [ADDR_IN_W-1:0]   rem_ff, rem_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [SAMPLE_W-1:0]    wsample_ff, wsample_in;

   // predict transaction
   logic signed [ORIGIN_W-1:0] ox_ff, ox_in;
   logic signed [ORIGIN_W-1:0] oy_ff, oy_in;
   logic [BS_W-1:0]        cols_ff, cols_in;
   logic [BS_W-1:0]        rows_ff, rows_in;
   logic [BI_W-1:0]        col_ff, col_in;
   logic [BI_W-1:0]        row_ff, row_in;
   logic [CX_W-1:0]        cx_ff, cx_in;
   logic [CY_W-1:0]        cy_ff, cy_in;
   logic [EIGHTH_BITS-1:0] dx_ff, dx_in;
   logic [EIGHTH_BITS-1:0] dy_ff, dy_in;
   logic                   plast_ff, plast_in;
   logic [1:0]             phase_ff, phase_in;

   // read tags, aligned with the registered memory data
   logic                   rd_valid_ff, rd_valid_in;
   logic [1:0]             rd_phase_ff, rd_phase_in;
   logic [WT_W-1:0]        rd_weight_ff, rd_weight_in;
   logic                   rd_last_ff, rd_last_in;
   logic [SAMPLE_W-1:0]    rd_data_ff;

   // blend accumulator and result register
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [SAMPLE_W-1:0]    rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic                   accept;
   logic [PW_W-1:0]        w_eff;
   logic [PH_W-1:0]        h_eff;
   logic [BS_W-1:0]        cols_sat, rows_sat;
   logic signed [POS_W-1:0] pos_x, pos_y;
   logic [CMPX_W-1:0]      hi_x, x_cl;
   logic [CMPY_W-1:0]      hi_y, y_cl;
   logic [BI_W-1:0]        col_end, row_end;
   logic [ADDR_IN_W-1:0]   span_sub;
   logic                   rd_en;
   logic [CX_W-1:0]        rd_col;
   logic [CY_W-1:0]        rd_row;
   logic [ADDR_W-1:0]      rd_addr;
   logic [EIGHTH_BITS:0]   wx, wy;
   logic [ACC_W-1:0]       acc_sum, acc_round;

   // sample memory
   logic [SAMPLE_W-1:0]    sample_mem [SAMPLE_DEPTH];

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_pixel  = rsp_pixel_ff;
   assign rsp_last   = rsp_last_ff;

   // plane sizes: zero acts as one, oversize saturates
   always_comb begin
      if (pw_ff == '0) begin
         w_eff = PW_W'(1);
      end else if (32'(pw_ff) > MAX_PLANE_WIDTH) begin
         w_eff = PW_W'(MAX_PLANE_WIDTH);
      end else begin
         w_eff = PW_W'(pw_ff);
      end
      if (ph_ff == '0) begin
         h_eff = PH_W'(1);
      end else if (32'(ph_ff) > MAX_PLANE_HEIGHT) begin
         h_eff = PH_W'(MAX_PLANE_HEIGHT);
      end else begin
         h_eff = PH_W'(ph_ff);
      end
   end

   // block sizes saturate to the largest block
   assign cols_sat = (32'(req_block_cols) > MAX_BLOCK_SIZE) ? BS_W'(MAX_BLOCK_SIZE)
                                                            : BS_W'(req_block_cols);
   assign rows_sat = (32'(req_block_rows) > MAX_BLOCK_SIZE) ? BS_W'(MAX_BLOCK_SIZE)
                                                            : BS_W'(req_block_rows);
   assign col_end  = BI_W'(cols_ff - 1'b1);
   assign row_end  = BI_W'(rows_ff - 1'b1);

   // pixel position in eighths, clamped to the plane on each axis
   assign pos_x = POS_W'(ox_ff) + POS_W'({col_ff, {EIGHTH_BITS{1'b0}}});
   assign pos_y = POS_W'(oy_ff) + POS_W'({row_ff, {EIGHTH_BITS{1'b0}}});
   assign hi_x  = CMPX_W'(w_eff - 1'b1) << EIGHTH_BITS;
   assign hi_y  = CMPY_W'(h_eff - 1'b1) << EIGHTH_BITS;

   always_comb begin
      if (pos_x[POS_W-1]) begin
         x_cl = '0;
      end else if (CMPX_W'(pos_x[POS_W-2:0]) > hi_x) begin
         x_cl = hi_x;
      end else begin
         x_cl = CMPX_W'(pos_x[POS_W-2:0]);
      end
      if (pos_y[POS_W-1]) begin
         y_cl = '0;
      end else if (CMPY_W'(pos_y[POS_W-2:0]) > hi_y) begin
         y_cl = hi_y;
      end else begin
         y_cl = CMPY_W'(pos_y[POS_W-2:0]);
      end
   end

   // neighbor selection; a zero fraction stays on the base sample, which
   // keeps the address inside the plane and the weight kills the term
   assign rd_en  = (state_ff == S_READ);
   assign rd_col = cx_ff + CX_W'((dx_ff != '0) && (phase_ff == PH_B || phase_ff == PH_D));
   assign rd_row = cy_ff + CY_W'((dy_ff != '0) && (phase_ff == PH_C || phase_ff == PH_D));
   assign rd_addr = ADDR_W'(rd_row * w_eff) + ADDR_W'(rd_col);

   // bilinear weight of the neighbor read in this phase
   assign wx = (phase_ff == PH_B || phase_ff == PH_D) ? {1'b0, dx_ff}
                                                      : FRAC_ONE - {1'b0, dx_ff};
   assign wy = (phase_ff == PH_C || phase_ff == PH_D) ? {1'b0, dy_ff}
                                                      : FRAC_ONE - {1'b0, dy_ff};

   // shifted depth for the current reduction step
   assign span_sub = ADDR_IN_W'(SAMPLE_DEPTH) << k_ff;

   // accumulate weighted samples as they return from memory
   assign acc_sum   = ((rd_phase_ff == PH_A) ? '0 : acc_ff)
                      + ACC_W'(rd_weight_ff) * ACC_W'(rd_data_ff);
   assign acc_round = acc_sum + ACC_W'(ROUND_BIAS);

   always_comb begin
      state_in      = state_ff;
      pw_in         = pw_ff;
      ph_in         = ph_ff;
      rem_in        = rem_ff;
      k_in          = k_ff;
      wsample_in    = wsample_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      plast_in      = plast_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PLANE_WIDTH:  pw_in = csr_data;
            CSR_PLANE_HEIGHT: ph_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  rem_in     = req_write_address;
                  wsample_in = req_write_sample;
                  k_in       = K_W'(MOD_STEPS - 1);
                  state_in   = (MOD_STEPS > 0) ? S_REDUCE : S_WRITE;
               end else begin
                  ox_in   = req_origin_x;
                  oy_in   = req_origin_y;
                  cols_in = cols_sat;
                  rows_in = rows_sat;
                  col_in  = '0;
                  row_in  = '0;
                  // an empty block yields nothing
                  if (cols_sat != '0 && rows_sat != '0) begin
                     state_in = S_SETUP;
                  end
               end
            end
         end
         S_REDUCE: begin
            if (rem_ff >= span_sub) begin
               rem_in = rem_ff - span_sub;
            end
            if (k_ff == '0) begin
               state_in = S_WRITE;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         S_SETUP: begin
            cx_in    = x_cl[XP_W-1:EIGHTH_BITS];
            dx_in    = x_cl[EIGHTH_BITS-1:0];
            cy_in    = y_cl[YP_W-1:EIGHTH_BITS];
            dy_in    = y_cl[EIGHTH_BITS-1:0];
            plast_in = (col_ff == col_end) && (row_ff == row_end);
            phase_in = PH_A;
            state_in = S_READ;
         end
         S_READ: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == PH_D) begin
               if (col_ff == col_end) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = plast_ff ? S_DRAIN : S_SETUP;
            end
         end
         S_DRAIN: begin
            // last sample of the block returns this cycle
            if (rd_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rd_valid_ff) begin
         acc_in = acc_sum;
         if (rd_phase_ff == PH_D) begin
            rsp_strobe_in = 1'b1;
            rsp_pixel_in  = acc_round[ACC_W-1:BLEND_SHIFT];
            rsp_last_in   = rd_last_ff;
         end
      end
   end

   // tags travel alongside the memory read
   assign rd_valid_in  = rd_en;
   assign rd_phase_in  = phase_ff;
   assign rd_weight_in = WT_W'(wx) * WT_W'(wy);
   assign rd_last_in   = plast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pw_ff         <= PLANE_SIZE_RESET;
         ph_ff         <= PLANE_SIZE_RESET;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pw_ff         <= pw_in;
         ph_ff         <= ph_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      k_ff         <= k_in;
      wsample_ff   <= wsample_in;
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      plast_ff     <= plast_in;
      phase_ff     <= phase_in;
      rd_phase_ff  <= rd_phase_in;
      rd_weight_ff <= rd_weight_in;
      rd_last_ff   <= rd_last_in;
      acc_ff       <= acc_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         sample_mem[ADDR_W'(rem_ff)] <= wsample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem[rd_addr];
      end
   end

`ifndef ASSERT_OFF
   // the final pixel of a block leaves the sequencer idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (state_ff == S_IDLE))
      else $error("last pixel strobed while sequencer still active");

   // returning read data always belongs to an issued read
   a_read_tag: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == S_READ))
      else $error("read tag without a read");

   // neighbor addresses stay inside the memory
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (32'(rd_addr) < SAMPLE_DEPTH))
      else $error("sample read address beyond memory depth");

   // a pixel is strobed only after its fourth neighbor was accumulated
   a_four_reads: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(rd_valid_ff && (rd_phase_ff == PH_D)))
      else $error("pixel strobed without a complete blend");
`endif

endmodule
